### design/kabf_pkg.sv
package kabf_pkg;

  // Fixed-point layout shared by the arithmetic units.
  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned MUL_DIGIT_W = 16;
  localparam int unsigned MUL_DIGITS  = 4;
  // Gain dividend magnitude (|P| << 24) and divisor (P00 + R) widths.
  localparam int unsigned DIV_NUM_W   = 56;
  localparam int unsigned DIV_DEN_W   = 34;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // Reset values of the noise registers, unsigned Q8.24.
  localparam logic [31:0] Q_ANGLE_RST  = 32'd16777;
  localparam logic [31:0] Q_BIAS_RST   = 32'd50332;
  localparam logic [31:0] MEAS_VAR_RST = 32'd503316;

  typedef enum logic [1:0] {
    CFG_Q_ANGLE  = 2'd0,
    CFG_Q_BIAS   = 2'd1,
    CFG_MEAS_VAR = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRED_ANG,
    S_PRED_T1,
    S_PRED_P00,
    S_PRED_P11,
    S_GAIN0,
    S_GAIN1,
    S_CORR_ANG,
    S_CORR_BIAS,
    S_COV10,
    S_COV00,
    S_COV11,
    S_COV01,
    S_OUT
  } step_e;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic        [23:0] elapsed_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } out_t;

  // Operation request to a shared unit.
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } op_req_t;

  // Status and result of a shared unit.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] res;
  } unit_rsp_t;

  // Saturate a 64-bit value to a signed 32-bit word.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

### design/kabf_mul.sv
module kabf_mul
  import kabf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_req_t   req_i,
  output unit_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [2:0]  cnt_q;
  logic        neg_q;
  logic [63:0] ma_q, mb_q;
  logic [127:0] acc_q;
  logic signed [63:0] res_q;

  logic [79:0]  prod;
  logic [127:0] rnd;
  logic [103:0] shr;
  logic [63:0]  mag;
  logic signed [63:0] fin;

  // One 64x16 partial product per cycle, most significant digit first.
  assign prod = ma_q * mb_q[63:64-MUL_DIGIT_W];

  // Round to nearest (ties away from zero), saturate, then restore the sign.
  always_comb begin
    rnd = acc_q + 128'(64'd1 << (FRAC_BITS - 1));
    shr = rnd[127:FRAC_BITS];
    mag = (|shr[103:63]) ? 64'(S64_MAX) : shr[63:0];
    fin = neg_q ? -$signed(mag) : $signed(mag);
  end

  // Control of the digit loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q && cnt_q < 3'(MUL_DIGITS)) begin
      cnt_q <= cnt_q + 3'd1;
    end else if (busy_q) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand magnitudes, accumulator and result.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[63] ^ req_i.b[63];
      ma_q  <= req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
      mb_q  <= req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
      acc_q <= '0;
    end else if (busy_q && cnt_q < 3'(MUL_DIGITS)) begin
      acc_q <= {acc_q[127-MUL_DIGIT_W:0], MUL_DIGIT_W'(0)} + 128'(prod);
      mb_q  <= {mb_q[63-MUL_DIGIT_W:0], MUL_DIGIT_W'(0)};
    end else if (busy_q) begin
      res_q <= fin;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

### design/kabf_div.sv
module kabf_div
  import kabf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_req_t   req_i,
  output unit_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 neg_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q;
  logic signed [63:0]   res_q;

  logic [DIV_DEN_W:0]   sh;
  logic [DIV_DEN_W+1:0] diff;
  logic [63:0]          q64;

  // One restoring step: shift in the next dividend bit and try the divisor.
  always_comb begin
    sh   = {rem_q, quo_q[DIV_NUM_W-1]};
    diff = {1'b0, sh} - {2'b00, den_q};
    q64  = 64'(quo_q);
  end

  // Control of the bit loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q && cnt_q < CNT_W'(DIV_NUM_W)) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (busy_q) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient shift register; the quotient truncates toward zero.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[63];
      quo_q <= req_i.a[63] ? DIV_NUM_W'(-req_i.a) : DIV_NUM_W'(req_i.a);
      den_q <= DIV_DEN_W'(req_i.b);
      rem_q <= '0;
    end else if (busy_q && cnt_q < CNT_W'(DIV_NUM_W)) begin
      if (!diff[DIV_DEN_W+1]) begin
        rem_q <= diff[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= sh[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
    end else if (busy_q) begin
      res_q <= neg_q ? -$signed(q64) : $signed(q64);
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

### design/angle_bias_kalman_filter.sv
// A transaction runs ten products through the shared 64x16 multiplier and two
// gain divisions of 56 quotient bits each; each operation is issued, then written back.
// When the innovation variance is not positive the divisions are skipped.
// A new transaction is taken only when the sequencer is idle, and the last step
// waits while a previous result is still stalled in the output register.
// Reset: asynchronous, active low; clears states, covariance and the output
// valid, and loads the noise registers with their default values.
module angle_bias_kalman_filter
  import kabf_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic signed [63:0] DW_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] DW_MIN = -DW_MAX - 64'sd1;

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [63:0] v);
    if (v > DW_MAX) begin
      return DW_MAX[DATA_WIDTH-1:0];
    end else if (v < DW_MIN) begin
      return DW_MIN[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [63:0] ext_dw(input logic signed [DATA_WIDTH-1:0] v);
    return 64'(v);
  endfunction

  step_e step_q, step_d;
  logic  wait_q, wait_d;

  logic [31:0] q_angle_q, q_bias_q, meas_var_q;

  logic signed [DATA_WIDTH-1:0] angle_q, angle_d, bias_q, bias_d, y_q, y_d;
  logic signed [31:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  logic signed [63:0] t1_q, t1_d, k0_q, k0_d, k1_q, k1_d;

  logic signed [31:0] meas_angle_q, meas_rate_q;
  logic        [23:0] dt_q;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  op_req_t   mul_req, div_req;
  unit_rsp_t mul_rsp, div_rsp;

  logic                         in_acc;
  logic signed [63:0]           dt64, inner, s, m;
  logic                         s_pos;
  logic signed [DATA_WIDTH-1:0] rate, y_c;

  kabf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  kabf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (step_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Shared operands of the prediction and correction steps.
  always_comb begin
    dt64  = 64'(dt_q);
    rate  = sat_dw(64'(meas_rate_q) - ext_dw(bias_q));
    inner = t1_q - 64'(p01_q) - 64'(p10_q) + 64'(q_angle_q);
    s     = 64'(p00_q) + 64'(meas_var_q);
    s_pos = !s[63] && (|s);
    y_c   = sat_dw(64'(meas_angle_q) - ext_dw(angle_q));
    m     = mul_rsp.res;
  end

  // Sequencer: each arithmetic step issues one operation, then writes back when it is done.
  always_comb begin
    step_d      = step_q;
    wait_d      = wait_q;
    angle_d     = angle_q;
    bias_d      = bias_q;
    y_d         = y_q;
    p00_d       = p00_q;
    p01_d       = p01_q;
    p10_d       = p10_q;
    p11_d       = p11_q;
    t1_d        = t1_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mul_req     = '0;
    div_req     = '0;
    div_req.b   = s;

    case (step_q)
      S_IDLE: begin
        if (in_acc) begin
          step_d = S_PRED_ANG;
          wait_d = 1'b0;
        end
      end
      S_PRED_ANG: begin
        mul_req.a = dt64;
        mul_req.b = ext_dw(rate);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          angle_d = sat_dw(ext_dw(angle_q) + m);
          step_d  = S_PRED_T1;
          wait_d  = 1'b0;
        end
      end
      S_PRED_T1: begin
        mul_req.a = dt64;
        mul_req.b = 64'(p11_q);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          t1_d   = m;
          step_d = S_PRED_P00;
          wait_d = 1'b0;
        end
      end
      S_PRED_P00: begin
        mul_req.a = dt64;
        mul_req.b = inner;
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          p00_d  = sat32(64'(p00_q) + m);
          p01_d  = sat32(64'(p01_q) - t1_q);
          p10_d  = sat32(64'(p10_q) - t1_q);
          step_d = S_PRED_P11;
          wait_d = 1'b0;
        end
      end
      S_PRED_P11: begin
        mul_req.a = 64'(q_bias_q);
        mul_req.b = dt64;
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          p11_d  = sat32(64'(p11_q) + m);
          step_d = S_GAIN0;
          wait_d = 1'b0;
        end
      end
      S_GAIN0: begin
        div_req.a = {{8{p00_q[31]}}, p00_q, FRAC_BITS'(0)};
        if (!wait_q) begin
          if (s_pos) begin
            div_req.start = 1'b1;
            wait_d        = 1'b1;
          end else begin
            // Innovation variance not positive: both gains are zero.
            k0_d   = '0;
            k1_d   = '0;
            step_d = S_CORR_ANG;
          end
        end else if (div_rsp.done) begin
          k0_d   = div_rsp.res;
          step_d = S_GAIN1;
          wait_d = 1'b0;
        end
      end
      S_GAIN1: begin
        div_req.a = {{8{p10_q[31]}}, p10_q, FRAC_BITS'(0)};
        if (!wait_q) begin
          div_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (div_rsp.done) begin
          k1_d   = div_rsp.res;
          step_d = S_CORR_ANG;
          wait_d = 1'b0;
        end
      end
      S_CORR_ANG: begin
        mul_req.a = k0_q;
        mul_req.b = ext_dw(y_c);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          y_d           = y_c;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          angle_d = sat_dw(ext_dw(angle_q) + m);
          step_d  = S_CORR_BIAS;
          wait_d  = 1'b0;
        end
      end
      S_CORR_BIAS: begin
        mul_req.a = k1_q;
        mul_req.b = ext_dw(y_q);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          bias_d = sat_dw(ext_dw(bias_q) + m);
          step_d = S_COV10;
          wait_d = 1'b0;
        end
      end
      // P10 goes before P00 and P11 before P01, so each uses the predicted value.
      S_COV10: begin
        mul_req.a = k1_q;
        mul_req.b = 64'(p00_q);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          p10_d  = sat32(64'(p10_q) - m);
          step_d = S_COV00;
          wait_d = 1'b0;
        end
      end
      S_COV00: begin
        mul_req.a = k0_q;
        mul_req.b = 64'(p00_q);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          p00_d  = sat32(64'(p00_q) - m);
          step_d = S_COV11;
          wait_d = 1'b0;
        end
      end
      S_COV11: begin
        mul_req.a = k1_q;
        mul_req.b = 64'(p01_q);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          p11_d  = sat32(64'(p11_q) - m);
          step_d = S_COV01;
          wait_d = 1'b0;
        end
      end
      S_COV01: begin
        mul_req.a = k0_q;
        mul_req.b = 64'(p01_q);
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          p01_d  = sat32(64'(p01_q) - m);
          step_d = S_OUT;
          wait_d = 1'b0;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.angle_estimate = sat32(ext_dw(angle_q));
          out_d.bias_estimate  = sat32(ext_dw(bias_q));
          step_d               = S_IDLE;
        end
      end
      default: begin
        step_d = S_IDLE;
        wait_d = 1'b0;
      end
    endcase
  end

  // Control, filter state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      angle_q     <= '0;
      bias_q      <= '0;
      p00_q       <= '0;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= '0;
      q_angle_q   <= Q_ANGLE_RST;
      q_bias_q    <= Q_BIAS_RST;
      meas_var_q  <= MEAS_VAR_RST;
    end else begin
      step_q      <= step_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      angle_q     <= angle_d;
      bias_q      <= bias_d;
      p00_q       <= p00_d;
      p01_q       <= p01_d;
      p10_q       <= p10_d;
      p11_q       <= p11_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_Q_ANGLE:  q_angle_q  <= cfg_wdata_i;
          CFG_Q_BIAS:   q_bias_q   <= cfg_wdata_i;
          CFG_MEAS_VAR: meas_var_q <= cfg_wdata_i;
          default:      ;
        endcase
      end
    end
  end

  // Working values and the captured transaction.
  always_ff @(posedge clk_i) begin
    t1_q  <= t1_d;
    k0_q  <= k0_d;
    k1_q  <= k1_d;
    y_q   <= y_d;
    out_q <= out_d;
    if (in_acc) begin
      meas_angle_q <= in_data_i.measured_angle;
      meas_rate_q  <= in_data_i.measured_rate;
      dt_q         <= in_data_i.elapsed_time;
    end
  end

  // A transaction is only taken by an idle sequencer, which then starts predicting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> step_q == S_PRED_ANG)
    else $error("input taken but prediction did not start");

  // The multiplier and the divider are never busy together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy at once");

  // A unit only completes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_rsp.done || div_rsp.done) |-> wait_q)
    else $error("unit completed with no pending operation");

  // When the output register is free, the final step loads a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_OUT && !(out_valid_q && out_stall_i)) |=> (out_valid_q && step_q == S_IDLE))
    else $error("result not loaded into the output register");

endmodule
